// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define R64_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("encoder assertion failed");
`define R64_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("encoder forbidden condition seen");
`else
`define R64_ASSERT(lbl, clk, rstn, prop)
`define R64_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ===== hdl/r64enc_pkg.sv =====
// Types, constants and the alphabet function of the radix-64 crypt encoder.
package r64enc_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;
  localparam logic [15:0] CAP_RESET = 16'd64;
  localparam logic REG_OUTPUT_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    ST_CHAR = 2'd0,
    ST_TERM = 2'd1,
    ST_OVFL = 2'd2
  } status_t;

  typedef struct packed {
    logic [23:0] word;
    logic [2:0]  nchar;
    logic        tail;
    status_t     tail_status;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] crypt_char(input logic [5:0] g);
    logic [7:0] c;
    case (g) inside
      [6'd0:6'd11]: begin
        c = 8'd46 + {2'b00, g};
      end
      [6'd12:6'd37]: begin
        c = 8'd53 + {2'b00, g};
      end
      default: begin
        c = 8'd59 + {2'b00, g};
      end
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/r64enc_if.sv =====
// Valid/ready channel interfaces for the encoder's byte input and result output.
interface r64enc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface r64enc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic [1:0] status;
  logic       run_end;

  modport source (output valid, output out_char, output status, output run_end, input ready);
  modport sink (input valid, input out_char, input status, input run_end, output ready);
endinterface

// ===== hdl/r64enc_front.sv =====
// Front end: accepts bytes, gathers groups of three and plans the results of each beat.
module r64enc_front (
  input  logic                clk,
  input  logic                rst_n,
  r64enc_in_if.sink           in_bus,
  input  logic [15:0]         capacity,
  input  r64enc_pkg::q_stat_t q_stat,
  output logic                push,
  output r64enc_pkg::job_t    job
);
  import r64enc_pkg::*;

  logic [15:0] pend_r, pend_nxt;
  logic [1:0]  count_r, count_nxt;
  logic [15:0] cw_r, cw_nxt;
  logic        drop_r, drop_nxt;

  logic        accept;
  logic        fin;
  logic        emit;
  logic [2:0]  groups;
  logic [15:0] avail;
  logic        ovf;
  logic [2:0]  k;

  assign in_bus.ready = !q_stat.full;
  assign accept = in_bus.valid && in_bus.ready;
  assign fin = in_bus.final_byte;
  assign emit = (count_r == 2'd2) || fin;

  always_comb begin
    case (count_r)
      2'd0: begin
        groups = 3'd2;
        job.word = {in_bus.data_byte, 16'h0000};
      end
      2'd1: begin
        groups = 3'd3;
        job.word = {pend_r[7:0], in_bus.data_byte, 8'h00};
      end
      default: begin
        groups = 3'd4;
        job.word = {pend_r, in_bus.data_byte};
      end
    endcase
    avail = (cw_r >= capacity) ? 16'd0 : capacity - cw_r;
    ovf = avail < {13'd0, groups};
    k = ovf ? avail[2:0] : groups;
    job.nchar = k;
    job.tail = ovf || fin;
    if (ovf || (avail == {13'd0, groups})) begin
      job.tail_status = ST_OVFL;
    end else begin
      job.tail_status = ST_TERM;
    end
  end

  assign push = accept && !drop_r && emit;

  always_comb begin
    pend_nxt = pend_r;
    count_nxt = count_r;
    cw_nxt = cw_r;
    drop_nxt = drop_r;
    if (accept) begin
      if (drop_r) begin
        if (fin) begin
          pend_nxt = 16'h0000;
          count_nxt = 2'd0;
          cw_nxt = 16'd0;
          drop_nxt = 1'b0;
        end
      end else if (emit) begin
        pend_nxt = 16'h0000;
        count_nxt = 2'd0;
        if (fin) begin
          cw_nxt = 16'd0;
        end else if (ovf) begin
          drop_nxt = 1'b1;
        end else begin
          cw_nxt = cw_r + {13'd0, k};
        end
      end else begin
        pend_nxt = {pend_r[7:0], in_bus.data_byte};
        count_nxt = count_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 16'h0000;
      count_r <= 2'd0;
      cw_r <= 16'd0;
      drop_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      count_r <= count_nxt;
      cw_r <= cw_nxt;
      drop_r <= drop_nxt;
    end
  end

endmodule

// ===== hdl/r64enc_queue.sv =====
// Short queue of planned jobs between the front and back ends.
module r64enc_queue #(
  parameter int DEPTH = r64enc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  r64enc_pkg::job_t    push_job,
  input  logic                pop,
  output r64enc_pkg::q_stat_t q_stat,
  output r64enc_pkg::job_t    head_job
);
  import r64enc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign q_stat.full = (count_r == CW'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head_job = mem_r[rd_ptr_r];
  assign do_push = push && !q_stat.full;
  assign do_pop = pop && !q_stat.empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== hdl/r64enc_back.sv =====
// Back end: walks each job one result a cycle into the output register while the output accepts.
module r64enc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  r64enc_pkg::q_stat_t q_stat,
  input  r64enc_pkg::job_t    head_job,
  output logic                pop,
  r64enc_out_if.source        out_bus
);
  import r64enc_pkg::*;

  logic [2:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] char_r;
  status_t    status_r;
  logic       end_r;

  logic       load;
  logic [5:0] grp;
  logic [7:0] cur_char;
  status_t    cur_status;
  logic       cur_last;

  always_comb begin
    case (idx_r[1:0])
      2'd0: begin
        grp = head_job.word[23:18];
      end
      2'd1: begin
        grp = head_job.word[17:12];
      end
      2'd2: begin
        grp = head_job.word[11:6];
      end
      default: begin
        grp = head_job.word[5:0];
      end
    endcase
    if (idx_r < head_job.nchar) begin
      cur_char = crypt_char(grp);
      cur_status = ST_CHAR;
      cur_last = (idx_r == head_job.nchar - 3'd1) && !head_job.tail;
    end else begin
      cur_char = 8'h00;
      cur_status = head_job.tail_status;
      cur_last = 1'b1;
    end
  end

  assign load = !q_stat.empty && (!valid_r || out_bus.ready);
  assign pop = load && cur_last;

  always_comb begin
    idx_nxt = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt = cur_last ? 3'd0 : idx_r + 3'd1;
    end else if (out_bus.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 3'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= cur_char;
      status_r <= cur_status;
      end_r <= cur_last;
    end
  end

  assign out_bus.valid = valid_r;
  assign out_bus.out_char = char_r;
  assign out_bus.status = status_r;
  assign out_bus.run_end = end_r;

endmodule

// ===== hdl/radix64_crypt_alphabet_encoder.sv =====
// Radix-64 crypt alphabet encoder: top level with configuration port and assertions.
// A byte that completes a group is taken and its job pushed into the job queue; the
// back end loads its results into the output register one per cycle while the output
// accepts. Bytes are taken every cycle while the job queue has room; a group of three
// bytes gives at most four results and a final byte up to five.
// Synchronous active-low reset clears message state, queue and output valid; capacity resets to 64.
`include "assert_macros.svh"

module radix64_crypt_alphabet_encoder #(
  parameter int QUEUE_DEPTH = r64enc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  r64enc_in_if.sink    in_bus,
  r64enc_out_if.source out_bus,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import r64enc_pkg::*;

  logic [15:0] cap_r, cap_nxt;
  logic        push;
  logic        pop;
  job_t        push_job;
  job_t        head_job;
  q_stat_t     q_stat;

  assign pready = 1'b1;

  always_comb begin
    cap_nxt = cap_r;
    if (psel && penable && pwrite && (paddr[2] == REG_OUTPUT_CAPACITY)) begin
      cap_nxt = pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  assign prdata = (paddr[2] == REG_OUTPUT_CAPACITY) ? {16'h0000, cap_r} : 32'h0000_0000;

  r64enc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .capacity (cap_r),
    .q_stat   (q_stat),
    .push     (push),
    .job      (push_job)
  );

  r64enc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_stat   (q_stat),
    .head_job (head_job)
  );

  r64enc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .head_job (head_job),
    .pop      (pop),
    .out_bus  (out_bus)
  );

  `R64_NEVER(a_no_push_when_full, clk, rst_n, push && q_stat.full)
  `R64_ASSERT(a_push_fills_queue, clk, rst_n, push |=> !q_stat.empty)
  `R64_ASSERT(a_tail_ends_run, clk, rst_n, (out_bus.valid && (out_bus.status != ST_CHAR)) |-> (out_bus.run_end && (out_bus.out_char == 8'h00)))

endmodule
